/* rtl/rmpu_pkg.sv */
// ----------------------------------------------------------------------------
// rmpu_pkg
// Shared types and constants for the range maximum store: field layout,
// request and status codes, controller states and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package rmpu_pkg;

    localparam int DEFAULT_CAPACITY = 1024;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int COUNT_W  = 11;

    // Input item layout in s_tdata, lowest bits first
    localparam int FIRST_LSB  = 0;
    localparam int LAST_LSB   = FIRST_LSB + POS_W;
    localparam int VALUE_LSB  = LAST_LSB + POS_W;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Configuration port
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_ELEMENT_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 11'd1024;

    localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic walk_en;
        logic scan_en;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic walk_more;
        logic scan_more;
        logic req_err;
        logic req_query;
    } dp_status_t;

    function automatic logic signed [VALUE_W-1:0] max_of(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

/* rtl/range_max_point_update.sv */
// ----------------------------------------------------------------------------
// range_max_point_update
// Array of signed 32-bit values with point writes and range maximum queries.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser is the kind (write or query),
// s_tdata carries the positions and the value. One result item per request
// leaves on the m_ channel: m_tdata is the maximum (zero for writes and
// rejected requests), m_tuser is the status.
// A write stores the leaf and climbs the max tree one level per cycle, one
// sibling read each, up to the root. A query narrows the range one tree level
// per cycle, reading both range ends through the two memory read ports. A
// rejected request goes straight to the result. One request is in flight at
// a time; the next item is taken the cycle after its result is loaded.
// The result sits in an output register, so a new request is taken while a
// finished result waits; a stalled receiver holds the block only once the
// next result is ready.
// After reset the node memory is swept to the most negative value, one entry
// per cycle over all 2*CAPACITY entries; s_tready stays low until it is done.
// element_count is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module range_max_point_update #(
    parameter int CAPACITY = rmpu_pkg::DEFAULT_CAPACITY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: first_position[9:0], last_position[19:10], new_value[51:20], zero fill
    input  logic [rmpu_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: req_type
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: max_value[31:0]
    output logic [rmpu_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: status
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rmpu_pkg::PADDR_W-1:0]      paddr,
    input  logic [rmpu_pkg::PDATA_W-1:0]      pwdata,
    output logic [rmpu_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    rmpu_pkg::dp_cmd_t    cmd;
    rmpu_pkg::dp_status_t status;

    logic [rmpu_pkg::COUNT_W-1:0] elem_count_reg, elem_count_next;
    logic                         reg_hit;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == rmpu_pkg::REG_ELEMENT_COUNT);

    always_comb begin
        elem_count_next = elem_count_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            elem_count_next = pwdata[rmpu_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elem_count_reg <= rmpu_pkg::ELEMENT_COUNT_RESET;
        end else begin
            elem_count_reg <= elem_count_next;
        end
    end

    assign prdata = reg_hit ? rmpu_pkg::PDATA_W'(elem_count_reg) : '0;

    rmpu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmpu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .element_count (elem_count_reg),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

`ifndef SYNTH
    // No item is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !s_tready)
        else $error("item accepted during clearing sweep");

    // A result is loaded only into a free output register
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result loaded over a waiting result");

    // One request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");
`endif

endmodule

/* rtl/rmpu_ctrl.sv */
// ----------------------------------------------------------------------------
// rmpu_ctrl
// Sequencer for the range maximum store: clearing pass, request intake,
// tree walk for writes, range scan for queries and result hand-off.
// ----------------------------------------------------------------------------
module rmpu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  rmpu_pkg::dp_status_t status,
    output rmpu_pkg::dp_cmd_t    cmd
);

    rmpu_pkg::ctrl_state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmpu_pkg::ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = rmpu_pkg::ST_IDLE;
                end
            end
            rmpu_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.req_err) begin
                        state_next = rmpu_pkg::ST_FINISH;
                    end else if (status.req_query) begin
                        state_next = rmpu_pkg::ST_SCAN;
                    end else begin
                        state_next = rmpu_pkg::ST_WALK;
                    end
                end
            end
            rmpu_pkg::ST_WALK: begin
                if (!status.walk_more) begin
                    state_next = rmpu_pkg::ST_FINISH;
                end
            end
            rmpu_pkg::ST_SCAN: begin
                if (!status.scan_more) begin
                    state_next = rmpu_pkg::ST_FINISH;
                end
            end
            rmpu_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rmpu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmpu_pkg::ST_CLEAR;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd          = '0;
        cmd.clear_en = (state_reg == rmpu_pkg::ST_CLEAR);
        cmd.accept   = (state_reg == rmpu_pkg::ST_IDLE) && s_tvalid;
        cmd.walk_en  = (state_reg == rmpu_pkg::ST_WALK);
        cmd.scan_en  = (state_reg == rmpu_pkg::ST_SCAN);
        cmd.load_out = (state_reg == rmpu_pkg::ST_FINISH) && out_free;
        s_tready     = (state_reg == rmpu_pkg::ST_IDLE);
    end

    // Hold the result valid until taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rmpu_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

/* rtl/rmpu_dp.sv */
// ----------------------------------------------------------------------------
// rmpu_dp
// Datapath of the range maximum store: one node memory holding the max tree
// (leaves at CAPACITY + position), walk and scan index registers, the
// running maximum and the result register.
// ----------------------------------------------------------------------------
module rmpu_dp #(
    parameter int CAPACITY = rmpu_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmpu_pkg::dp_cmd_t                    cmd,
    output rmpu_pkg::dp_status_t                 status,
    input  logic [rmpu_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic [rmpu_pkg::COUNT_W-1:0]         element_count,
    output logic [rmpu_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser
);

    localparam int AW    = $clog2(2 * CAPACITY);
    localparam int IW    = $clog2(2 * CAPACITY + 1);
    localparam int DEPTH = 2 * CAPACITY;
    localparam int VW    = rmpu_pkg::VALUE_W;
    localparam int PW    = rmpu_pkg::POS_W;

    // Node memory: index 1 is the root, CAPACITY + p is element p
    logic signed [VW-1:0] mem [0:DEPTH-1];

    logic [PW-1:0]        in_first, in_last;
    logic signed [VW-1:0] in_value;
    logic                 first_over, last_over;

    logic [AW-1:0]        clr_cnt_reg;
    logic [AW-1:0]        cur_reg;
    logic [IW-1:0]        lo_reg, hi_reg, hi_dec;
    logic signed [VW-1:0] acc_reg, best_reg;
    logic                 walk_vld_reg, scan_vld_reg;
    logic                 take0_reg, take1_reg;
    logic                 kind_reg, err_reg;
    logic signed [VW-1:0] rdata0_reg, rdata1_reg;
    logic signed [VW-1:0] out_value_reg;
    logic                 out_err_reg;

    logic                 we;
    logic [AW-1:0]        waddr, raddr0, raddr1;
    logic signed [VW-1:0] wdata, walk_max, cand0, cand1;

    // Unpack the request
    assign in_first = s_tdata[rmpu_pkg::FIRST_LSB +: PW];
    assign in_last  = s_tdata[rmpu_pkg::LAST_LSB +: PW];
    assign in_value = $signed(s_tdata[rmpu_pkg::VALUE_LSB +: VW]);

    // Check positions against the count in use and the capacity
    assign first_over = ({1'b0, in_first} >= element_count) ||
                        (32'(in_first) >= 32'(CAPACITY));
    assign last_over  = ({1'b0, in_last} >= element_count) ||
                        (32'(in_last) >= 32'(CAPACITY));

    assign hi_dec = hi_reg - IW'(1);

    always_comb begin
        status            = '0;
        status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
        status.walk_more  = (cur_reg > AW'(1));
        status.scan_more  = (lo_reg < hi_reg);
        status.req_query  = (s_tuser == rmpu_pkg::REQ_QUERY);
        status.req_err    = first_over ||
                            ((s_tuser == rmpu_pkg::REQ_QUERY) &&
                             (last_over || (in_first > in_last)));
    end

    // Write port: clearing sweep or tree walk
    assign walk_max = rmpu_pkg::max_of(acc_reg, rdata0_reg);

    always_comb begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = walk_vld_reg ? walk_max : acc_reg;
        if (cmd.clear_en) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = rmpu_pkg::MOST_NEGATIVE;
        end else if (cmd.walk_en) begin
            we = 1'b1;
        end
    end

    // Read ports: sibling on a walk, both range ends on a scan
    assign raddr0 = cmd.walk_en ? (cur_reg ^ AW'(1)) : lo_reg[AW-1:0];
    assign raddr1 = hi_dec[AW-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    // Clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en && !status.clear_last) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Pipeline flags for walk and scan reads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_vld_reg <= 1'b0;
            scan_vld_reg <= 1'b0;
        end else begin
            walk_vld_reg <= cmd.walk_en && status.walk_more;
            scan_vld_reg <= cmd.scan_en && status.scan_more;
        end
    end

    // Range ends taken into the running maximum
    assign cand0 = take0_reg ? rdata0_reg : rmpu_pkg::MOST_NEGATIVE;
    assign cand1 = take1_reg ? rdata1_reg : rmpu_pkg::MOST_NEGATIVE;

    // Request registers, walk and scan indices
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_tuser;
            err_reg  <= status.req_err;
            acc_reg  <= in_value;
            best_reg <= rmpu_pkg::MOST_NEGATIVE;
            cur_reg  <= AW'(CAPACITY) + AW'(in_first);
            lo_reg   <= IW'(CAPACITY) + IW'(in_first);
            hi_reg   <= IW'(CAPACITY) + IW'(in_last) + IW'(1);
        end else begin
            // Walk: write node, fetch sibling, climb one level
            if (cmd.walk_en) begin
                acc_reg <= wdata;
                if (status.walk_more) begin
                    cur_reg <= cur_reg >> 1;
                end
            end
            // Scan: fetch odd ends, narrow the range one level
            if (cmd.scan_en && status.scan_more) begin
                take0_reg <= lo_reg[0];
                take1_reg <= hi_reg[0];
                lo_reg    <= (lo_reg + IW'(lo_reg[0])) >> 1;
                hi_reg    <= hi_reg >> 1;
            end
            if (scan_vld_reg) begin
                best_reg <= rmpu_pkg::max_of(best_reg, rmpu_pkg::max_of(cand0, cand1));
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_err_reg <= err_reg;
            if (err_reg || (kind_reg == rmpu_pkg::REQ_WRITE)) begin
                out_value_reg <= '0;
            end else begin
                out_value_reg <= best_reg;
            end
        end
    end

    assign m_tdata = out_value_reg;
    assign m_tuser = out_err_reg ? rmpu_pkg::STATUS_INVALID : rmpu_pkg::STATUS_DONE;

endmodule

/* sim/rmpu_tb_pkg.sv */
// ----------------------------------------------------------------------------
// rmpu_tb_pkg
// Shadow array and result tracking for the range maximum store testbench.
// Every accepted in-range write updates a plain copy of the array; every
// accepted request queues the result it must produce. Every result leaving
// the block is compared with the oldest queued one.
// ----------------------------------------------------------------------------
package rmpu_tb_pkg;

    import rmpu_pkg::*;

    // Register addresses on the configuration port
    localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = PADDR_W'(4 * int'(REG_ELEMENT_COUNT));
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED      = PADDR_W'(4);

    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic signed [VALUE_W-1:0] max_value;
        logic                      status;
    } range_result_t;

    class range_max_tracker;

        logic signed [VALUE_W-1:0] shadow_values [DEFAULT_CAPACITY];
        logic [COUNT_W-1:0]        shadow_count;
        range_result_t             pending_results [$];
        int unsigned               mismatches;
        int unsigned               n_writes;
        int unsigned               n_queries;
        int unsigned               n_rejects;
        int unsigned               n_results;

        function new();
            foreach (shadow_values[i]) shadow_values[i] = MOST_NEGATIVE;
            shadow_count = ELEMENT_COUNT_RESET;
            mismatches   = 0;
            n_writes     = 0;
            n_queries    = 0;
            n_rejects    = 0;
            n_results    = 0;
        endfunction

        // Only the element count register exists; other addresses are ignored
        function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
            if (addr == ADDR_ELEMENT_COUNT) shadow_count = value[COUNT_W-1:0];
        endfunction

        function int unsigned positions_in_use();
            return (shadow_count < DEFAULT_CAPACITY) ? shadow_count : DEFAULT_CAPACITY;
        endfunction

        // Apply one accepted request to the shadow array and queue its result
        function void note_request(logic kind, logic [POS_W-1:0] first,
                                   logic [POS_W-1:0] last, logic signed [VALUE_W-1:0] value);
            range_result_t             res;
            int unsigned               used;
            logic signed [VALUE_W-1:0] best;
            used          = positions_in_use();
            res.max_value = '0;
            res.status    = STATUS_DONE;
            if (kind == REQ_WRITE) begin
                n_writes++;
                if (first >= used) begin
                    res.status = STATUS_INVALID;
                end else begin
                    shadow_values[first] = value;
                end
            end else begin
                n_queries++;
                if (first >= used || last >= used || first > last) begin
                    res.status = STATUS_INVALID;
                end else begin
                    best = MOST_NEGATIVE;
                    for (int p = first; p <= last; p++) begin
                        if (shadow_values[p] > best) best = shadow_values[p];
                    end
                    res.max_value = best;
                end
            end
            if (res.status == STATUS_INVALID) n_rejects++;
            pending_results.push_back(res);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Compare one result item with the oldest queued result
        task check_result(logic [M_TDATA_W-1:0] data, logic status);
            range_result_t want;
            n_results++;
            if (pending_results.size() == 0) begin
                report($sformatf("result with none pending: max %h status %0d", data, status));
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 n_results, status, want.status));
            if (data !== want.max_value)
                report($sformatf("result %0d max %h, want %h",
                                 n_results, data, want.max_value));
        endtask

        task check_drained();
            if (pending_results.size() != 0)
                report($sformatf("%0d results never arrived", pending_results.size()));
        endtask

    endclass

endpackage

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for range_max_point_update.
// Drives write and query requests over the input stream and checks each
// result against a shadow copy of the array. A directed part covers the
// position and value extremes, empty and inverted ranges, never-written
// elements and element counts of zero, one and beyond capacity; random
// phases then run under several element counts with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rmpu_pkg::*;
    import rmpu_tb_pkg::*;

    localparam int TAIL_CYCLES = 30;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = REQ_WRITE;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [PADDR_W-1:0]     paddr     = '0;
    logic [PDATA_W-1:0]     pwdata    = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    logic                   no_idle   = 1'b0;
    range_max_tracker       tracker;

    range_max_point_update u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel now and then
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 11);
    end

    // Note accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_request(s_tuser, s_tdata[LAST_LSB-1:FIRST_LSB],
                                     s_tdata[VALUE_LSB-1:LAST_LSB],
                                     s_tdata[VALUE_LSB+VALUE_W-1:VALUE_LSB]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
        end
    end

    // Offer one item and hold it until taken, then idle at random
    task automatic send_request(input logic kind, input int unsigned first,
                                input int unsigned last, input logic [VALUE_W-1:0] value);
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-VALUE_LSB-VALUE_W){1'b0}}, value,
                     last[POS_W-1:0], first[POS_W-1:0]};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!no_idle) begin
            while ($urandom_range(99) < 11) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(addr, value);
        @(posedge aclk);
    endtask

    // Read back the element count and compare with the shadow copy
    task automatic apb_check_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ELEMENT_COUNT;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== PDATA_W'(tracker.shadow_count))
            tracker.report($sformatf("element_count reads %h, want %h",
                                     prdata, tracker.shadow_count));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_element_count(input int unsigned count);
        wait_drained();
        apb_write(ADDR_ELEMENT_COUNT, PDATA_W'(count));
        apb_check_count();
    endtask

    // One random request: mostly in range, small spans favoured, some noise
    task automatic random_request();
        int unsigned       used;
        int unsigned       pick;
        int unsigned       f;
        int unsigned       l;
        int unsigned       span;
        int unsigned       swap;
        logic              kind;
        logic [VALUE_W-1:0] value;
        used = tracker.positions_in_use();
        pick = $urandom_range(99);
        kind = ($urandom_range(1) == 0) ? REQ_WRITE : REQ_QUERY;
        case ($urandom_range(19))
            0:       value = MOST_NEGATIVE;
            1:       value = ~MOST_NEGATIVE;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom;
        endcase
        if (used == 0 || pick < 8) begin
            f = $urandom_range(DEFAULT_CAPACITY - 1);
            l = $urandom_range(DEFAULT_CAPACITY - 1);
        end else begin
            f    = $urandom_range(used - 1);
            span = (pick < 70) ? $urandom_range(15) : $urandom_range(used - 1);
            l    = (f + span > used - 1) ? used - 1 : f + span;
            // invert the range now and then
            if (pick >= 95) begin
                swap = f;
                f    = l;
                l    = swap;
            end
            if (kind == REQ_WRITE && pick < 50) l = $urandom_range(DEFAULT_CAPACITY - 1);
        end
        send_request(kind, f, l, value);
    endtask

    task automatic random_phase(input int unsigned count, input int unsigned n_items,
                                input logic quiet, input logic mid_drain);
        set_element_count(count);
        no_idle = quiet;
        for (int i = 0; i < n_items; i++) begin
            if (mid_drain && i == n_items / 2) wait_drained();
            random_request();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default count: never-written elements, value and position extremes
        send_request(REQ_QUERY, 0, 1023, '0);
        send_request(REQ_WRITE, 0, 1023, ~MOST_NEGATIVE);
        send_request(REQ_WRITE, 1023, 0, MOST_NEGATIVE);
        send_request(REQ_WRITE, 512, 511, '0);
        send_request(REQ_QUERY, 0, 1023, '1);
        send_request(REQ_QUERY, 1, 1023, '0);
        send_request(REQ_QUERY, 1023, 1023, '0);
        send_request(REQ_QUERY, 0, 0, '0);
        send_request(REQ_QUERY, 600, 5, '0);
        send_request(REQ_WRITE, 512, 0, '1);
        send_request(REQ_QUERY, 513, 1023, '0);
        send_request(REQ_QUERY, 511, 512, '0);

        // A single position in use
        set_element_count(1);
        send_request(REQ_WRITE, 1, 0, 32'd7);
        send_request(REQ_WRITE, 0, 0, 32'd5);
        send_request(REQ_QUERY, 0, 0, '0);
        send_request(REQ_QUERY, 0, 1, '0);
        send_request(REQ_QUERY, 1, 0, '0);

        // Unmapped register: count must stay at one
        wait_drained();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        apb_check_count();
        send_request(REQ_WRITE, 1023, 1023, '0);

        // No positions in use: everything rejected
        set_element_count(0);
        send_request(REQ_WRITE, 0, 0, 32'd9);
        send_request(REQ_QUERY, 0, 0, '0);

        // Count beyond capacity behaves as full capacity
        set_element_count(2047);
        send_request(REQ_QUERY, 0, 1023, '0);
        send_request(REQ_WRITE, 1023, 0, 32'h1234_5678);
        send_request(REQ_QUERY, 1000, 1023, '0);

        // Random phases over a spread of counts
        random_phase(1024, 200, 1'b0, 1'b1);
        random_phase(2047, 190, 1'b0, 1'b0);
        random_phase(1, 120, 1'b0, 1'b0);
        random_phase(37, 200, 1'b1, 1'b0);
        random_phase(0, 40, 1'b0, 1'b0);
        random_phase(5, 160, 1'b0, 1'b0);
        random_phase($urandom_range(1024, 2), 220, 1'b0, 1'b1);
        random_phase(1000, 200, 1'b0, 1'b0);
        random_phase(1024, 220, 1'b0, 1'b0);

        wait_drained();
        tracker.check_drained();
        $display("covered %0d writes and %0d queries, %0d rejected, %0d results checked",
                 tracker.n_writes, tracker.n_queries, tracker.n_rejects, tracker.n_results);
        $display("element counts 0, 1, 5, 37, 1000, 1024, 2047 and one random; unmapped write");
        if (tracker.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

/* range_max_point_update.f */
rtl/rmpu_pkg.sv
rtl/rmpu_ctrl.sv
rtl/rmpu_dp.sv
rtl/range_max_point_update.sv
sim/rmpu_tb_pkg.sv
sim/tb_top.sv
